/* rtl/obn_pkg.sv */
// ----------------------------------------------------------------------------
// obn_pkg: shared types and constants
// Payload structs, request and mode codes, register indexes and the
// command/status bundles between the navigation controller and its datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package obn_pkg;

  localparam int MAX_SLOTS      = 16;
  localparam int CARDS_PER_PAGE = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int DIV_N     = 32;
  localparam int DIV_CNT_W = $clog2(DIV_N + 1);
  localparam int DIVISOR_W = 16;
  localparam int MOD_W     = 3;

  localparam logic [2:0] REQ_TICK      = 3'd0;
  localparam logic [2:0] REQ_DOWN      = 3'd1;
  localparam logic [2:0] REQ_UP        = 3'd2;
  localparam logic [2:0] REQ_HEARTBEAT = 3'd3;
  localparam logic [2:0] REQ_MODEL     = 3'd4;

  localparam logic [1:0] MODE_BROWSE = 2'd0;
  localparam logic [1:0] MODE_SELECT = 2'd1;
  localparam logic [1:0] MODE_DETAIL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ARM_HOLD   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STALE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TOGGLE     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_WIPE_EN    = 3'd6;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] now_ms;
    logic [4:0]  card_count;
    logic        legend_present;
    logic [15:0] wipeable_mask;
  } item_t;

  typedef struct packed {
    logic [1:0]  nav_mode;
    logic [4:0]  selected;
    logic [2:0]  page_shown;
    logic        label_phase;
    logic        stale_flag;
    logic [15:0] hold_progress_ms;
    logic        wipe_fire;
    logic [3:0]  wipe_slot;
  } result_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_TSTALE,
    OP_TLONG,
    OP_TIDLE,
    OP_TPAGE,
    OP_EXEC
  } op_t;

  typedef struct packed {
    logic accept;
    op_t  op;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic item_is_tick;
    logic div_busy;
  } dp_status_t;

endpackage

`default_nettype wire

/* rtl/obn_div.sv */
// ----------------------------------------------------------------------------
// obn_div: serial divider with quotient residue
// Restoring division, one quotient bit per cycle, MSB first. The quotient is
// reduced modulo a small value as its bits appear.
// ----------------------------------------------------------------------------
`default_nettype none

module obn_div (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic [obn_pkg::DIV_N-1:0]       dividend,
  input  wire logic [obn_pkg::DIVISOR_W-1:0]   divisor,
  input  wire logic [obn_pkg::MOD_W-1:0]       modulus,
  output logic                                 busy,
  output logic [obn_pkg::MOD_W-1:0]            residue
);

  logic [obn_pkg::DIV_CNT_W-1:0] cnt;
  logic [obn_pkg::DIV_N-1:0]     num;
  logic [obn_pkg::DIVISOR_W-1:0] dvs;
  logic [obn_pkg::MOD_W-1:0]     md;
  logic [obn_pkg::DIVISOR_W-1:0] rem;
  logic [obn_pkg::MOD_W-1:0]     qm;

  logic [obn_pkg::DIVISOR_W:0]   rem_sh;
  logic                          ge;
  logic [obn_pkg::DIVISOR_W-1:0] rem_next;
  logic [obn_pkg::MOD_W:0]       qm_sh;
  logic [obn_pkg::MOD_W-1:0]     qm_next;

  always_comb begin
    rem_sh   = {rem, num[obn_pkg::DIV_N-1]};
    ge       = rem_sh >= {1'b0, dvs};
    rem_next = ge ? obn_pkg::DIVISOR_W'(rem_sh - {1'b0, dvs})
                  : rem_sh[obn_pkg::DIVISOR_W-1:0];
    qm_sh    = {qm, ge};
    qm_next  = (qm_sh >= {1'b0, md}) ? obn_pkg::MOD_W'(qm_sh - {1'b0, md})
                                     : qm_sh[obn_pkg::MOD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= obn_pkg::DIV_CNT_W'(obn_pkg::DIV_N);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      dvs <= divisor;
      md  <= modulus;
      rem <= '0;
      qm  <= '0;
    end else if (busy) begin
      num <= {num[obn_pkg::DIV_N-2:0], 1'b0};
      rem <= rem_next;
      qm  <= qm_next;
    end
  end

  assign busy    = cnt != '0;
  assign residue = qm;

endmodule

`default_nettype wire

/* rtl/obn_datapath.sv */
// ----------------------------------------------------------------------------
// obn_datapath: navigation state and step logic
// Holds configuration, navigation state and the result register, and applies
// one step of an event per command from the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module obn_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [obn_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [obn_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire obn_pkg::item_t                    item,
  input  wire obn_pkg::ctrl_cmd_t                cmd,
  output obn_pkg::dp_status_t                    status,
  output obn_pkg::result_t                       result
);

  typedef struct packed {
    logic [1:0]  mode;
    logic [4:0]  sel;
    logic [2:0]  page;
    logic        phase;
    logic        held;
    logic        long_done;
    logic        fire;
    logic [3:0]  fire_slot;
    logic [31:0] last_in;
  } nav_t;

  function automatic logic [2:0] page_total(input logic [4:0] cnt, input logic lg);
    logic [5:0] pages;
    pages = 6'((32'(cnt) + 32'(obn_pkg::CARDS_PER_PAGE - 1)) / obn_pkg::CARDS_PER_PAGE)
          + 6'(lg);
    if (pages == 6'd0) pages = 6'd1;
    page_total = pages[2:0];
  endfunction

  function automatic logic wipeable(input logic [4:0] sel, input logic [15:0] bits);
    wipeable = (sel < 5'd16) && bits[sel[3:0]];
  endfunction

  function automatic nav_t settle(input nav_t s, input logic [4:0] cnt, input logic lg);
    nav_t       r;
    logic [4:0] maxsel;
    r      = s;
    maxsel = cnt - 5'd1;
    if (r.mode != obn_pkg::MODE_BROWSE) begin
      if (cnt == 5'd0) begin
        r.mode = obn_pkg::MODE_BROWSE;
      end else begin
        if (r.mode == obn_pkg::MODE_SELECT && lg) maxsel = cnt;
        if (r.sel > maxsel) r.sel = maxsel;
      end
    end
    if (!(r.mode == obn_pkg::MODE_DETAIL && cnt != 5'd0) && !(cnt == 5'd0 && !lg)) begin
      if (r.mode == obn_pkg::MODE_SELECT && cnt != 5'd0) begin
        if (lg && r.sel == cnt) begin
          r.page = 3'd0;
        end else begin
          r.page = 3'(r.sel / obn_pkg::CARDS_PER_PAGE) + 3'(lg);
        end
      end
      if (r.page >= page_total(cnt, lg)) r.page = 3'd0;
    end
    settle = r;
  endfunction

  function automatic nav_t press(input nav_t s, input logic is_long, input logic stale,
                                 input logic [31:0] now, input logic [4:0] cnt,
                                 input logic lg, input logic [15:0] bits,
                                 input logic wen);
    nav_t       r;
    logic [5:0] stops;
    logic [5:0] nxt;
    r     = s;
    stops = {1'b0, cnt} + 6'(lg);
    nxt   = {1'b0, s.sel} + 6'd1;
    if (nxt >= stops) nxt = nxt - stops;
    if (!stale) begin
      r.last_in = now;
      if (r.mode == obn_pkg::MODE_BROWSE) begin
        if (cnt != 5'd0) begin
          r.mode = obn_pkg::MODE_SELECT;
          r.sel  = 5'd0;
        end
      end else if (r.mode == obn_pkg::MODE_SELECT) begin
        if (cnt == 5'd0) begin
          r.mode = obn_pkg::MODE_BROWSE;
        end else if (is_long) begin
          if (r.sel < cnt) r.mode = obn_pkg::MODE_DETAIL;
        end else begin
          r.sel = nxt[4:0];
        end
      end else begin
        if (is_long && wen && wipeable(r.sel, bits)) begin
          r.fire      = 1'b1;
          r.fire_slot = r.sel[3:0];
        end
        r.mode = obn_pkg::MODE_SELECT;
      end
      r = settle(r, cnt, lg);
    end
    press = r;
  endfunction

  // configuration
  logic [15:0] long_press_ms, arm_hold_ms, stale_limit, idle_ms, page_ms, phase_half;
  logic        wipe_enabled;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ms <= 16'd600;
      arm_hold_ms   <= 16'd5000;
      stale_limit   <= 16'd2000;
      idle_ms       <= 16'd12000;
      page_ms       <= 16'd4000;
      phase_half    <= 16'd2000;
      wipe_enabled  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        obn_pkg::CFG_LONG_PRESS: long_press_ms <= cfg_data;
        obn_pkg::CFG_ARM_HOLD:   arm_hold_ms   <= cfg_data;
        obn_pkg::CFG_STALE:      stale_limit   <= cfg_data;
        obn_pkg::CFG_IDLE:       idle_ms       <= cfg_data;
        obn_pkg::CFG_PAGE:       page_ms       <= cfg_data;
        obn_pkg::CFG_TOGGLE:     phase_half    <= cfg_data;
        obn_pkg::CFG_WIPE_EN:    wipe_enabled  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // captured event
  logic [2:0]  req_q;
  logic [31:0] now_q;
  logic [4:0]  cnt_in_q;
  logic        lg_in_q;
  logic [15:0] mask_in_q;
  logic        stale_q;
  logic [31:0] hb_age_in;
  logic        stale_in;

  // state
  nav_t        nav, nav_next;
  logic [4:0]  count_reg, count_reg_next;
  logic        legend_reg, legend_reg_next;
  logic [15:0] wipe_bits, wipe_bits_next;
  logic        hb_seen, hb_seen_next;
  logic [31:0] hb_time, hb_time_next;
  logic [31:0] press_time, press_time_next;

  assign hb_age_in = item.now_ms - hb_time;
  assign stale_in  = hb_seen && (hb_age_in > {16'd0, stale_limit});

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_q     <= item.req_type;
      now_q     <= item.now_ms;
      cnt_in_q  <= item.card_count;
      lg_in_q   <= item.legend_present;
      mask_in_q <= item.wipeable_mask;
      stale_q   <= stale_in;
    end
  end

  // dividers for the label phase and the browse page
  logic                          div_start;
  logic [obn_pkg::DIVISOR_W-1:0] tog_div, page_div;
  logic                          tog_busy, page_busy;
  logic [obn_pkg::MOD_W-1:0]     tog_res, page_res;

  assign div_start = cmd.accept && status.item_is_tick;
  assign tog_div   = (phase_half == 16'd0) ? 16'd1 : phase_half;
  assign page_div  = (page_ms == 16'd0) ? 16'd1 : page_ms;

  obn_div u_tog_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (item.now_ms),
    .divisor  (tog_div),
    .modulus  (3'd2),
    .busy     (tog_busy),
    .residue  (tog_res)
  );

  obn_div u_page_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (item.now_ms),
    .divisor  (page_div),
    .modulus  (page_total(count_reg, legend_reg)),
    .busy     (page_busy),
    .residue  (page_res)
  );

  assign status.item_is_tick = item.req_type == obn_pkg::REQ_TICK;
  assign status.div_busy     = tog_busy | page_busy;

  // step logic
  nav_t        t;
  logic [15:0] thr;
  logic [31:0] press_age;
  logic [31:0] input_age;
  logic        ph;
  logic [2:0]  pg;

  assign press_age = now_q - press_time;
  assign input_age = now_q - nav.last_in;

  always_comb begin
    nav_next        = nav;
    count_reg_next  = count_reg;
    legend_reg_next = legend_reg;
    wipe_bits_next  = wipe_bits;
    hb_seen_next    = hb_seen;
    hb_time_next    = hb_time;
    press_time_next = press_time;
    t               = nav;
    thr = (nav.mode == obn_pkg::MODE_DETAIL && wipeable(nav.sel, wipe_bits))
          ? arm_hold_ms : long_press_ms;
    ph  = tog_res[0];
    pg  = (nav.mode == obn_pkg::MODE_BROWSE) ? page_res : nav.page;

    unique case (cmd.op)
      obn_pkg::OP_NONE: ;
      obn_pkg::OP_TSTALE: begin
        if (stale_q && (nav.mode != obn_pkg::MODE_BROWSE || nav.held)) begin
          t.mode      = obn_pkg::MODE_BROWSE;
          t.held      = 1'b0;
          t.long_done = 1'b0;
          nav_next    = settle(t, count_reg, legend_reg);
        end
      end
      obn_pkg::OP_TLONG: begin
        if (nav.held && !nav.long_done && press_age >= {16'd0, thr}) begin
          t.long_done = 1'b1;
          nav_next    = press(t, 1'b1, stale_q, now_q, count_reg, legend_reg,
                              wipe_bits, wipe_enabled);
        end
      end
      obn_pkg::OP_TIDLE: begin
        if (nav.mode != obn_pkg::MODE_BROWSE && input_age > {16'd0, idle_ms}) begin
          t.mode   = obn_pkg::MODE_BROWSE;
          nav_next = settle(t, count_reg, legend_reg);
        end
      end
      obn_pkg::OP_TPAGE: begin
        if (nav.mode != obn_pkg::MODE_DETAIL && (ph != nav.phase || pg != nav.page)) begin
          t.phase  = ph;
          t.page   = pg;
          nav_next = settle(t, count_reg, legend_reg);
        end
      end
      obn_pkg::OP_EXEC: begin
        priority case (req_q)
          obn_pkg::REQ_DOWN: begin
            if (!stale_q) begin
              nav_next.held      = 1'b1;
              nav_next.long_done = 1'b0;
              nav_next.last_in   = now_q;
              press_time_next    = now_q;
            end
          end
          obn_pkg::REQ_UP: begin
            if (nav.held) begin
              t.held   = 1'b0;
              nav_next = t;
              if (!nav.long_done) begin
                nav_next = press(t, 1'b0, stale_q, now_q, count_reg, legend_reg,
                                 wipe_bits, wipe_enabled);
              end
            end
          end
          obn_pkg::REQ_HEARTBEAT: begin
            hb_seen_next = 1'b1;
            hb_time_next = now_q;
          end
          obn_pkg::REQ_MODEL: begin
            count_reg_next  = (cnt_in_q > 5'(obn_pkg::MAX_SLOTS))
                              ? 5'(obn_pkg::MAX_SLOTS) : cnt_in_q;
            legend_reg_next = lg_in_q;
            wipe_bits_next  = mask_in_q;
            nav_next        = settle(nav, count_reg_next, legend_reg_next);
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    if (cmd.accept) begin
      nav_next.fire      = 1'b0;
      nav_next.fire_slot = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nav        <= '0;
      count_reg  <= '0;
      legend_reg <= 1'b0;
      wipe_bits  <= '0;
      hb_seen    <= 1'b0;
      hb_time    <= '0;
      press_time <= '0;
    end else begin
      nav        <= nav_next;
      count_reg  <= count_reg_next;
      legend_reg <= legend_reg_next;
      wipe_bits  <= wipe_bits_next;
      hb_seen    <= hb_seen_next;
      hb_time    <= hb_time_next;
      press_time <= press_time_next;
    end
  end

  // result
  logic [31:0]       hb_age;
  logic [15:0]       hold;
  obn_pkg::result_t  res_next;

  assign hb_age = now_q - hb_time;

  always_comb begin
    hold = 16'd0;
    if (nav.mode == obn_pkg::MODE_DETAIL && nav.held && !nav.long_done &&
        wipeable(nav.sel, wipe_bits)) begin
      hold = (press_age > {16'd0, arm_hold_ms}) ? arm_hold_ms : press_age[15:0];
    end
    res_next.nav_mode         = nav.mode;
    res_next.selected         = nav.sel;
    res_next.page_shown       = nav.page;
    res_next.label_phase      = nav.phase;
    res_next.stale_flag       = hb_seen && (hb_age > {16'd0, stale_limit});
    res_next.hold_progress_ms = hold;
    res_next.wipe_fire        = nav.fire;
    res_next.wipe_slot        = nav.fire_slot;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result <= res_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/obn_ctrl.sv */
// ----------------------------------------------------------------------------
// obn_ctrl: event sequencer
// Accepts an event, walks the datapath through the steps of its handling and
// hands the finished result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module obn_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 item_valid,
  output logic                      item_ready,
  output logic                      result_valid,
  input  wire logic                 result_ready,
  input  wire obn_pkg::dp_status_t  status,
  output obn_pkg::ctrl_cmd_t        cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_TSTALE = 8'b0000_0010,
    S_TLONG  = 8'b0000_0100,
    S_TIDLE  = 8'b0000_1000,
    S_TWAIT  = 8'b0001_0000,
    S_TPAGE  = 8'b0010_0000,
    S_EXEC   = 8'b0100_0000,
    S_RESULT = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign item_ready = state == S_IDLE;
  assign out_free   = !result_valid || result_ready;

  always_comb begin
    state_next   = state;
    cmd.accept   = 1'b0;
    cmd.op       = obn_pkg::OP_NONE;
    cmd.out_load = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.accept = 1'b1;
          state_next = status.item_is_tick ? S_TSTALE : S_EXEC;
        end
      end
      S_TSTALE: begin
        cmd.op     = obn_pkg::OP_TSTALE;
        state_next = S_TLONG;
      end
      S_TLONG: begin
        cmd.op     = obn_pkg::OP_TLONG;
        state_next = S_TIDLE;
      end
      S_TIDLE: begin
        cmd.op     = obn_pkg::OP_TIDLE;
        state_next = S_TWAIT;
      end
      S_TWAIT: begin
        if (!status.div_busy) state_next = S_TPAGE;
      end
      S_TPAGE: begin
        cmd.op     = obn_pkg::OP_TPAGE;
        state_next = S_RESULT;
      end
      S_EXEC: begin
        cmd.op     = obn_pkg::OP_EXEC;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/one_button_nav_controller.sv */
// ----------------------------------------------------------------------------
// one_button_nav_controller: one-button navigation controller
// Timestamped events drive browse/select/detail navigation, press detection,
// idle fallback, stale-feed lockout and wipe arming.
//
//   channel   signals                               transfer when
//   item      item_valid / item_ready / item        valid & ready
//   result    result_valid / result_ready / result  valid & ready
//   cfg       cfg_we / cfg_index / cfg_data         cfg_we high
//
// One event at a time. Button, heartbeat and model events go through the
// execute and result states; a tick waits on the 32-step serial dividers
// for the label phase and the browse page. item_ready is high only while no
// event is in progress; an event may be taken while the previous result
// still waits in the output register. Synchronous reset restores the
// register defaults and clears the navigation and sequencer state.
// ----------------------------------------------------------------------------
`default_nettype none

module one_button_nav_controller (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             item_valid,
  output logic                                  item_ready,
  input  wire obn_pkg::item_t                   item,
  output logic                                  result_valid,
  input  wire logic                             result_ready,
  output obn_pkg::result_t                      result,
  input  wire logic                             cfg_we,
  input  wire logic [obn_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [obn_pkg::CFG_DATA_W-1:0]   cfg_data
);

  obn_pkg::ctrl_cmd_t  cmd;
  obn_pkg::dp_status_t status;

  obn_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .cmd          (cmd)
  );

  obn_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

endmodule

`default_nettype wire

/* rtl/obn_checker.sv */
// ----------------------------------------------------------------------------
// obn_checker: port-level checks
// Watches the result channel and the input handshake of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module obn_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              item_valid,
  input wire logic              item_ready,
  input wire logic              result_valid,
  input wire logic              result_ready,
  input wire obn_pkg::result_t  result
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  a_slot_quiet: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.wipe_fire |-> result.wipe_slot == 4'd0)
    else $error("wipe slot without fire");

  a_fire_mode: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.wipe_fire |->
      result.nav_mode == obn_pkg::MODE_SELECT && result.hold_progress_ms == 16'd0)
    else $error("wipe fire outside select");

  a_hold_detail: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.hold_progress_ms != 16'd0 |->
      result.nav_mode == obn_pkg::MODE_DETAIL)
    else $error("hold progress outside detail");

  a_one_event: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("second event taken back to back");

endmodule

bind one_button_nav_controller obn_checker u_obn_checker (.*);

`default_nettype wire

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for one_button_nav_controller
// Drives timestamped events with random gaps and back-pressure. An in-bench
// model of the navigation logic predicts every result view, which is
// compared field by field as each result transfer completes. The run covers
// the register defaults, several register settings (both extremes and zero
// periods), a short directed sequence and press-session random traffic.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  localparam logic [2:0] REQ_SPARE_LO = 3'd5;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 800000;
  localparam int unsigned TICK_DRAIN = 40;

  class nav_scoreboard;
    bit [15:0] long_press, arm_hold, stale_lim, idle_lim, page_per, toggle_per;
    bit        wipe_en;
    bit [1:0]  mode;
    bit [4:0]  sel;
    bit [2:0]  page;
    bit        phase;
    bit        hb_seen, held, long_done, legend, fire;
    bit [31:0] hb_t, last_in_t, press_t;
    bit [4:0]  cards;
    bit [15:0] wipe_bits;
    bit [3:0]  fire_slot;
    obn_pkg::result_t due_views[$];
    int        errors;
    int        checked;

    function new();
      long_press = 600; arm_hold = 5000; stale_lim = 2000;
      idle_lim = 12000; page_per = 4000; toggle_per = 2000; wipe_en = 0;
      mode = obn_pkg::MODE_BROWSE; sel = 0; page = 0; phase = 0;
      hb_seen = 0; held = 0; long_done = 0; legend = 0; fire = 0;
      hb_t = 0; last_in_t = 0; press_t = 0; cards = 0; wipe_bits = 0;
      fire_slot = 0; errors = 0; checked = 0;
    endfunction

    function void set_reg(logic [2:0] idx, bit [15:0] val);
      case (idx)
        obn_pkg::CFG_LONG_PRESS: long_press = val;
        obn_pkg::CFG_ARM_HOLD:   arm_hold = val;
        obn_pkg::CFG_STALE:      stale_lim = val;
        obn_pkg::CFG_IDLE:       idle_lim = val;
        obn_pkg::CFG_PAGE:       page_per = val;
        obn_pkg::CFG_TOGGLE:     toggle_per = val;
        obn_pkg::CFG_WIPE_EN:    wipe_en = val[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return due_views.size();
    endfunction

    function bit stale_at(bit [31:0] now);
      bit [31:0] d;
      d = now - hb_t;
      return hb_seen && (d > stale_lim);
    endfunction

    function bit sel_wipeable();
      return (sel < 16) && wipe_bits[sel[3:0]];
    endfunction

    function int unsigned page_total();
      int unsigned p;
      p = (cards + 3) / obn_pkg::CARDS_PER_PAGE + legend;
      return (p < 1) ? 1 : p;
    endfunction

    function void settle();
      int unsigned maxsel;
      if (mode != obn_pkg::MODE_BROWSE) begin
        if (cards == 0) begin
          mode = obn_pkg::MODE_BROWSE;
        end else begin
          maxsel = cards - 1;
          if (mode == obn_pkg::MODE_SELECT && legend) maxsel = cards;
          if (sel > maxsel) sel = 5'(maxsel);
        end
      end
      if (mode == obn_pkg::MODE_DETAIL && cards > 0) return;
      if (cards == 0 && !legend) return;
      if (mode == obn_pkg::MODE_SELECT && cards > 0)
        page = (legend && sel == cards) ? 3'd0
             : 3'(legend + sel / obn_pkg::CARDS_PER_PAGE);
      if (page >= page_total()) page = 0;
    endfunction

    function void press_action(bit is_long, bit [31:0] now);
      int unsigned stops;
      if (stale_at(now)) return;
      last_in_t = now;
      if (mode == obn_pkg::MODE_BROWSE) begin
        if (cards > 0) begin
          mode = obn_pkg::MODE_SELECT;
          sel = 0;
        end
      end else if (mode == obn_pkg::MODE_SELECT) begin
        if (cards == 0) begin
          mode = obn_pkg::MODE_BROWSE;
        end else if (is_long) begin
          if (sel < cards) mode = obn_pkg::MODE_DETAIL;
        end else begin
          stops = cards + legend;
          sel = 5'((sel + 1) % stops);
        end
      end else begin
        if (is_long && wipe_en && sel_wipeable()) begin
          fire = 1;
          fire_slot = sel[3:0];
        end
        mode = obn_pkg::MODE_SELECT;
      end
      settle();
    endfunction

    function void tick(bit [31:0] now);
      bit [31:0] thr, d, tper, pper, q;
      bit ph;
      int unsigned pg, pc;
      if (stale_at(now) && (mode != obn_pkg::MODE_BROWSE || held)) begin
        mode = obn_pkg::MODE_BROWSE;
        held = 0;
        long_done = 0;
        settle();
      end
      thr = 32'((mode == obn_pkg::MODE_DETAIL && sel_wipeable()) ? arm_hold : long_press);
      d = now - press_t;
      if (held && !long_done && d >= thr) begin
        long_done = 1;
        press_action(1'b1, now);
      end
      d = now - last_in_t;
      if (mode != obn_pkg::MODE_BROWSE && d > idle_lim) begin
        mode = obn_pkg::MODE_BROWSE;
        settle();
      end
      if (mode == obn_pkg::MODE_DETAIL) return;
      tper = (toggle_per == 0) ? 32'd1 : 32'(toggle_per);
      pper = (page_per == 0) ? 32'd1 : 32'(page_per);
      q = now / tper;
      ph = q[0];
      pg = 32'(page);
      if (mode == obn_pkg::MODE_BROWSE) begin
        pc = page_total();
        pg = (pc > 1) ? (now / pper) % pc : 0;
      end
      if (ph != phase || pg != page) begin
        phase = ph;
        page = 3'(pg);
        settle();
      end
    endfunction

    // works out the view after one accepted event and queues it
    function void predict_view(obn_pkg::item_t it);
      obn_pkg::result_t r;
      bit [31:0]        now, hold;
      now = it.now_ms;
      fire = 0;
      fire_slot = 0;
      case (it.req_type)
        obn_pkg::REQ_TICK: tick(now);
        obn_pkg::REQ_DOWN: begin
          if (!stale_at(now)) begin
            held = 1;
            long_done = 0;
            press_t = now;
            last_in_t = now;
          end
        end
        obn_pkg::REQ_UP: begin
          if (held) begin
            held = 0;
            if (!long_done) press_action(1'b0, now);
          end
        end
        obn_pkg::REQ_HEARTBEAT: begin
          hb_seen = 1;
          hb_t = now;
        end
        obn_pkg::REQ_MODEL: begin
          cards = (it.card_count > obn_pkg::MAX_SLOTS) ? 5'(obn_pkg::MAX_SLOTS)
                                                       : it.card_count;
          legend = it.legend_present;
          wipe_bits = it.wipeable_mask;
          settle();
        end
        default: ;
      endcase
      hold = 0;
      if (mode == obn_pkg::MODE_DETAIL && held && !long_done && sel_wipeable()) begin
        hold = now - press_t;
        if (hold > arm_hold) hold = 32'(arm_hold);
      end
      r.nav_mode = mode;
      r.selected = sel;
      r.page_shown = page;
      r.label_phase = phase;
      r.stale_flag = stale_at(now);
      r.hold_progress_ms = hold[15:0];
      r.wipe_fire = fire;
      r.wipe_slot = fire_slot;
      due_views.push_back(r);
    endfunction

    task report(string field, longint unsigned got_v, longint unsigned want_v);
      $display("result %0d: %s got %0d want %0d", checked, field, got_v, want_v);
      errors++;
    endtask

    task check_result(obn_pkg::result_t got);
      obn_pkg::result_t want;
      checked++;
      if (due_views.size() == 0) begin
        report("unexpected transfer, nav_mode", got.nav_mode, 0);
        return;
      end
      want = due_views.pop_front();
      if (got.nav_mode !== want.nav_mode) report("nav_mode", got.nav_mode, want.nav_mode);
      if (got.selected !== want.selected) report("selected", got.selected, want.selected);
      if (got.page_shown !== want.page_shown)
        report("page_shown", got.page_shown, want.page_shown);
      if (got.label_phase !== want.label_phase)
        report("label_phase", got.label_phase, want.label_phase);
      if (got.stale_flag !== want.stale_flag)
        report("stale_flag", got.stale_flag, want.stale_flag);
      if (got.hold_progress_ms !== want.hold_progress_ms)
        report("hold_progress_ms", got.hold_progress_ms, want.hold_progress_ms);
      if (got.wipe_fire !== want.wipe_fire) report("wipe_fire", got.wipe_fire, want.wipe_fire);
      if (got.wipe_slot !== want.wipe_slot) report("wipe_slot", got.wipe_slot, want.wipe_slot);
    endtask
  endclass

  logic                           clk;
  logic                           rst = 1'b1;
  logic                           item_valid = 1'b0;
  logic                           item_ready;
  obn_pkg::item_t                 item = '0;
  logic                           result_valid;
  logic                           result_ready = 1'b0;
  obn_pkg::result_t               result;
  logic                           cfg_we = 1'b0;
  logic [obn_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [obn_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  nav_scoreboard sb = new();
  bit [31:0]     clock_ms = 0;
  int unsigned   sent = 0;
  int unsigned   cycle_count = 0;
  bit            drv_calm = 0;
  bit            rx_calm = 0;

  one_button_nav_controller DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function int unsigned pick_gap(bit calm);
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side: random back-pressure, checked on each completed transfer
  initial begin
    int unsigned stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 199) == 0) rx_calm = ~rx_calm;
      if (stall > 0) begin
        result_ready <= 1'b0;
        stall--;
      end else begin
        result_ready <= 1'b1;
        stall = pick_gap(rx_calm);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) sb.check_result(result);
  end

  // called and returns at a falling edge; valid stays up after the transfer
  task send_item(obn_pkg::item_t it);
    int unsigned gap;
    if ($urandom_range(0, 63) == 0) drv_calm = ~drv_calm;
    gap = pick_gap(drv_calm);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (!item_ready);
    sb.predict_view(it);
    if (it.req_type <= obn_pkg::REQ_MODEL) sent++;
    @(negedge clk);
  endtask

  task post(logic [2:0] req, logic [31:0] now);
    obn_pkg::item_t it;
    it.req_type = req;
    it.now_ms = now;
    it.card_count = 5'($urandom);
    it.legend_present = 1'($urandom);
    it.wipeable_mask = 16'($urandom);
    send_item(it);
  endtask

  task post_model(logic [31:0] now, logic [4:0] cnt, logic leg, logic [15:0] mask);
    obn_pkg::item_t it;
    it.req_type = obn_pkg::REQ_MODEL;
    it.now_ms = now;
    it.card_count = cnt;
    it.legend_present = leg;
    it.wipeable_mask = mask;
    send_item(it);
  endtask

  task hold_off();
    item_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task write_reg(logic [2:0] idx, int val);
    if (val >= 0) begin
      cfg_we <= 1'b1;
      cfg_index <= idx;
      cfg_data <= 16'(val);
      sb.set_reg(idx, 16'(val));
      @(negedge clk);
    end
  endtask

  // a negative value leaves that register as it is
  task apply_settings(int lp, int ah, int st, int il, int pg, int tg, int we);
    hold_off();
    repeat (4) @(negedge clk);
    write_reg(obn_pkg::CFG_LONG_PRESS, lp);
    write_reg(obn_pkg::CFG_ARM_HOLD, ah);
    write_reg(obn_pkg::CFG_STALE, st);
    write_reg(obn_pkg::CFG_IDLE, il);
    write_reg(obn_pkg::CFG_PAGE, pg);
    write_reg(obn_pkg::CFG_TOGGLE, tg);
    write_reg(obn_pkg::CFG_WIPE_EN, we);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function int unsigned span_hint();
    case ($urandom_range(0, 5))
      0: return sb.long_press + 1;
      1: return sb.arm_hold + 1;
      2: return sb.stale_lim + 1;
      3: return sb.idle_lim + 1;
      4: return sb.page_per + 1;
      default: return sb.toggle_per + 1;
    endcase
  endfunction

  // down, some ticks while held, up; hold lengths around both thresholds
  task press_session();
    bit [31:0]   press_at, span;
    int unsigned k;
    if ($urandom_range(0, 9) < 7) post(obn_pkg::REQ_HEARTBEAT, clock_ms);
    clock_ms += $urandom_range(0, 20);
    press_at = clock_ms;
    post(obn_pkg::REQ_DOWN, press_at);
    case ($urandom_range(0, 2))
      0: span = $urandom_range(0, sb.long_press);
      1: span = sb.long_press + $urandom_range(0, sb.long_press);
      default: span = sb.arm_hold + $urandom_range(0, sb.arm_hold / 4 + 1);
    endcase
    k = $urandom_range(0, 4);
    for (int i = 1; i <= k; i++) begin
      clock_ms = press_at + span * i / (k + 1);
      if ($urandom_range(0, 1)) post(obn_pkg::REQ_HEARTBEAT, clock_ms);
      post(obn_pkg::REQ_TICK, clock_ms);
    end
    clock_ms = press_at + span;
    if ($urandom_range(0, 1)) post(obn_pkg::REQ_TICK, clock_ms);
    post(obn_pkg::REQ_UP, clock_ms);
  endtask

  task run_random(int unsigned n);
    int unsigned    goal, roll;
    obn_pkg::item_t it;
    goal = sent + n;
    while (sent < goal) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        post_model(clock_ms,
                   5'(($urandom_range(0, 9) < 6) ? $urandom_range(1, 16)
                                                 : $urandom_range(0, 31)),
                   1'($urandom),
                   ($urandom_range(0, 3) == 0) ? 16'hFFFF :
                   ($urandom_range(0, 2) == 0) ? 16'h0000 : 16'($urandom));
      end else if (roll < 16) begin
        post(obn_pkg::REQ_HEARTBEAT, clock_ms);
      end else if (roll < 56) begin
        press_session();
      end else if (roll < 84) begin
        clock_ms += $urandom_range(0, span_hint());
        post(obn_pkg::REQ_TICK, clock_ms);
      end else if (roll < 90) begin
        if ($urandom_range(0, 2) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 100000);
        else clock_ms += $urandom_range(0, 140000);
        post(obn_pkg::REQ_TICK, clock_ms);
      end else if (roll < 99) begin
        it.req_type = 3'($urandom_range(0, 7));
        it.now_ms = $urandom_range(0, 1) ? clock_ms : $urandom;
        it.card_count = 5'($urandom);
        it.legend_present = 1'($urandom);
        it.wipeable_mask = 16'($urandom);
        if ($urandom_range(0, 3) == 0) clock_ms = it.now_ms;
        send_item(it);
      end else begin
        hold_off();
      end
    end
  endtask

  task directed_run();
    bit [31:0] t;
    t = 32'd1000;
    post(obn_pkg::REQ_TICK, t);
    post(obn_pkg::REQ_UP, t + 1);                      // release with nothing held
    post(REQ_SPARE_LO, t + 2);
    post(REQ_SPARE_HI, t + 3);
    post_model(t + 4, 5'd31, 1'b1, 16'hFFFF);          // card count saturates
    post(obn_pkg::REQ_HEARTBEAT, t + 4);
    post(obn_pkg::REQ_DOWN, t + 10);
    post(obn_pkg::REQ_UP, t + 20);                     // browse -> select
    post(obn_pkg::REQ_DOWN, t + 30);
    post(obn_pkg::REQ_UP, t + 40);                     // next slot
    post(obn_pkg::REQ_DOWN, t + 50);
    post(obn_pkg::REQ_TICK, t + 110);                  // long press -> detail
    post(obn_pkg::REQ_UP, t + 115);
    post(obn_pkg::REQ_DOWN, t + 120);
    post(obn_pkg::REQ_TICK, t + 220);                  // arming in progress
    post(obn_pkg::REQ_TICK, t + 330);                  // arm hold complete, wipe
    post(obn_pkg::REQ_UP, t + 335);
    post_model(t + 340, 5'd2, 1'b1, 16'h0000);
    post(obn_pkg::REQ_TICK, t + 2000);                 // feed stale
    post(obn_pkg::REQ_DOWN, t + 2001);                 // locked out
    post(obn_pkg::REQ_HEARTBEAT, 32'hFFFF_FF00);
    post(obn_pkg::REQ_TICK, 32'hFFFF_FFFF);
    post(obn_pkg::REQ_TICK, 32'h0000_0010);            // across the wrap
    post_model(32'h20, 5'd3, 1'b0, 16'h0001);
    post(obn_pkg::REQ_DOWN, 32'h30);
    post(obn_pkg::REQ_UP, 32'h40);
    post(obn_pkg::REQ_HEARTBEAT, 32'h40 + 3000);
    post(obn_pkg::REQ_TICK, 32'h40 + 3100);            // idle fallback
    clock_ms = 32'h40 + 3100;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    run_random(150);
    apply_settings(50, 200, 1000, 3000, 400, 100, 1);
    directed_run();
    run_random(300);
    apply_settings(1, 1, 1, 1, 1, 1, 1);
    run_random(120);
    apply_settings(65535, 65535, 65535, 65535, 65535, 65535, 0);
    run_random(120);
    apply_settings(20, 60, -1, -1, 0, 0, 1);
    run_random(150);
    repeat (2) begin
      apply_settings($urandom_range(1, 3000), $urandom_range(1, 3000),
                     $urandom_range(1, 3000), $urandom_range(1, 6000),
                     $urandom_range(1, 3000), $urandom_range(1, 3000),
                     $urandom_range(0, 1));
      run_random(150);
    end

    hold_off();
    repeat (TICK_DRAIN) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
